// ----- rtl/tpc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Touch calibration package
// Shared widths, register indexes, reset values and types of the
// three-point touch calibration block.
// ----------------------------------------------------------------------------
package tpc_pkg;

    localparam int COORD_BITS = 10;
    localparam int OUT_BITS   = 16;

    localparam int PAIR_W = 4 * COORD_BITS;
    localparam int D_W    = COORD_BITS + 1;
    localparam int G_W    = 2 * COORD_BITS + 1;
    localparam int DIV_W  = 2 * COORD_BITS + 2;
    localparam int H_W    = 3 * COORD_BITS + 1;
    localparam int COEF_W = 3 * COORD_BITS + 4;
    localparam int NUM_W  = COEF_W + 2;
    localparam int MAG_W  = NUM_W;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAIR_0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAIR_1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAIR_2 = 2'd2;

    localparam logic [PAIR_W-1:0] PAIR_0_RST = 40'h00_0000_0000;
    localparam logic [PAIR_W-1:0] PAIR_1_RST = 40'hFF_C00F_FC00;
    localparam logic [PAIR_W-1:0] PAIR_2_RST = 40'h00_3FF0_03FF;

    localparam logic [1:0] DERIVE_CYCLES = 2'd3;

    localparam logic [MAG_W-1:0] OUT_POS_LIM = MAG_W'((64'd1 << (OUT_BITS - 1)) - 64'd1);
    localparam logic [MAG_W-1:0] OUT_NEG_LIM = MAG_W'(64'd1 << (OUT_BITS - 1));

    typedef struct packed {
        logic vld;
        logic neg_x;
        logic neg_y;
    } t_div_tag;

endpackage
`default_nettype wire

// ----- rtl/tpc_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined dual-lane divider
// Unsigned restoring division of two numerators by one shared divisor,
// one quotient bit per stage, with a tag that travels beside the data.
// ----------------------------------------------------------------------------
module tpc_div (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_en,
    input  wire [tpc_pkg::MAG_W-1:0]     i_num_x,
    input  wire [tpc_pkg::MAG_W-1:0]     i_num_y,
    input  wire [tpc_pkg::DIV_W-1:0]     i_den,
    input  wire tpc_pkg::t_div_tag       i_tag,
    output logic [tpc_pkg::MAG_W-1:0]    o_quo_x,
    output logic [tpc_pkg::MAG_W-1:0]    o_quo_y,
    output tpc_pkg::t_div_tag            o_tag
);

    localparam int MW = tpc_pkg::MAG_W;
    localparam int DW = tpc_pkg::DIV_W;

    logic [DW-1:0]     r_rem_x [MW];
    logic [DW-1:0]     r_rem_y [MW];
    logic [MW-1:0]     r_nq_x  [MW];
    logic [MW-1:0]     r_nq_y  [MW];
    tpc_pkg::t_div_tag r_tag   [MW];

    for (genvar k = 0; k < MW; k++) begin : g_stage
        logic [DW-1:0]     rem_in_x;
        logic [DW-1:0]     rem_in_y;
        logic [MW-1:0]     nq_in_x;
        logic [MW-1:0]     nq_in_y;
        tpc_pkg::t_div_tag tag_in;
        logic [DW:0]       cmp_x;
        logic [DW:0]       cmp_y;
        logic              ge_x;
        logic              ge_y;
        logic [DW-1:0]     n_rem_x;
        logic [DW-1:0]     n_rem_y;

        if (k == 0) begin : g_first
            assign rem_in_x = '0;
            assign rem_in_y = '0;
            assign nq_in_x  = i_num_x;
            assign nq_in_y  = i_num_y;
            assign tag_in   = i_tag;
        end else begin : g_next
            assign rem_in_x = r_rem_x[k-1];
            assign rem_in_y = r_rem_y[k-1];
            assign nq_in_x  = r_nq_x[k-1];
            assign nq_in_y  = r_nq_y[k-1];
            assign tag_in   = r_tag[k-1];
        end

        assign cmp_x = {rem_in_x, nq_in_x[MW-1]};
        assign cmp_y = {rem_in_y, nq_in_y[MW-1]};
        assign ge_x  = (cmp_x >= {1'b0, i_den});
        assign ge_y  = (cmp_y >= {1'b0, i_den});
        assign n_rem_x = ge_x ? DW'(cmp_x - {1'b0, i_den}) : cmp_x[DW-1:0];
        assign n_rem_y = ge_y ? DW'(cmp_y - {1'b0, i_den}) : cmp_y[DW-1:0];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem_x[k] <= n_rem_x;
                r_rem_y[k] <= n_rem_y;
                r_nq_x[k]  <= {nq_in_x[MW-2:0], ge_x};
                r_nq_y[k]  <= {nq_in_y[MW-2:0], ge_y};
                r_tag[k].neg_x <= tag_in.neg_x;
                r_tag[k].neg_y <= tag_in.neg_y;
            end
            if (!i_rst_n) begin
                r_tag[k].vld <= 1'b0;
            end else if (i_en) begin
                r_tag[k].vld <= tag_in.vld;
            end
        end
    end

    assign o_quo_x = r_nq_x[MW-1];
    assign o_quo_y = r_nq_y[MW-1];
    assign o_tag   = r_tag[MW-1];

endmodule
`default_nettype wire

// ----- rtl/touch_three_point_calibration.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Three-point touch calibration
// Maps raw touch readings to display coordinates with an affine transform
// derived from three reference pairs.
// ----------------------------------------------------------------------------
// The block takes one touch point per cycle unless the output stalls or the
// coefficients settle: three stages form the products, add them and take their
// magnitudes, a 36-stage divider produces one quotient bit per stage, and a
// final stage saturates. After reset and after every write to a pair register
// the input is held off while the three-stage coefficient pipeline settles.
module touch_three_point_calibration (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_in_valid,
    output logic                                 o_in_ready,
    input  wire [tpc_pkg::COORD_BITS-1:0]        i_touch_x,
    input  wire [tpc_pkg::COORD_BITS-1:0]        i_touch_y,
    output logic                                 o_out_valid,
    input  wire                                  i_out_ready,
    output logic signed [tpc_pkg::OUT_BITS-1:0]  o_mapped_x,
    output logic signed [tpc_pkg::OUT_BITS-1:0]  o_mapped_y,
    output logic                                 o_status,
    input  wire                                  i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire [tpc_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire [tpc_pkg::PAIR_W-1:0]            i_cfg_data
);

    localparam int CW  = tpc_pkg::COORD_BITS;
    localparam int OW  = tpc_pkg::OUT_BITS;
    localparam int PW  = tpc_pkg::PAIR_W;
    localparam int DFW = tpc_pkg::D_W;
    localparam int GW  = tpc_pkg::G_W;
    localparam int VW  = tpc_pkg::DIV_W;
    localparam int HW  = tpc_pkg::H_W;
    localparam int KW  = tpc_pkg::COEF_W;
    localparam int NW  = tpc_pkg::NUM_W;
    localparam int MW  = tpc_pkg::MAG_W;

    // Configuration and coefficient derivation.
    logic [PW-1:0] r_pair [3];
    logic [1:0]    r_busy;
    logic [1:0]    n_busy;
    logic          cfg_wr;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr = i_cfg_valid && (i_cfg_index == tpc_pkg::CFG_PAIR_0 ||
                                    i_cfg_index == tpc_pkg::CFG_PAIR_1 ||
                                    i_cfg_index == tpc_pkg::CFG_PAIR_2);

    always_comb begin
        if (cfg_wr) begin
            n_busy = tpc_pkg::DERIVE_CYCLES;
        end else if (r_busy != 2'd0) begin
            n_busy = r_busy - 2'd1;
        end else begin
            n_busy = r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair[0] <= tpc_pkg::PAIR_0_RST;
            r_pair[1] <= tpc_pkg::PAIR_1_RST;
            r_pair[2] <= tpc_pkg::PAIR_2_RST;
            r_busy    <= tpc_pkg::DERIVE_CYCLES;
        end else begin
            r_busy <= n_busy;
            if (cfg_wr) begin
                case (i_cfg_index)
                    tpc_pkg::CFG_PAIR_0: r_pair[0] <= i_cfg_data;
                    tpc_pkg::CFG_PAIR_1: r_pair[1] <= i_cfg_data;
                    tpc_pkg::CFG_PAIR_2: r_pair[2] <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    logic [CW-1:0] dx [3];
    logic [CW-1:0] dy [3];
    logic [CW-1:0] sx [3];
    logic [CW-1:0] sy [3];

    for (genvar i = 0; i < 3; i++) begin : g_field
        assign dx[i] = r_pair[i][4*CW-1:3*CW];
        assign dy[i] = r_pair[i][3*CW-1:2*CW];
        assign sx[i] = r_pair[i][2*CW-1:CW];
        assign sy[i] = r_pair[i][CW-1:0];
    end

    function automatic logic signed [DFW-1:0] diff(input logic [CW-1:0] a,
                                                    input logic [CW-1:0] b);
        diff = $signed({1'b0, a}) - $signed({1'b0, b});
    endfunction

    function automatic logic signed [GW-1:0] cross_term(input logic [CW-1:0] a,
                                                         input logic [CW-1:0] b,
                                                         input logic [CW-1:0] c,
                                                         input logic [CW-1:0] d);
        logic [GW-1:0] p;
        logic [GW-1:0] q;
        p = {{(GW-CW){1'b0}}, a} * {{(GW-CW){1'b0}}, b};
        q = {{(GW-CW){1'b0}}, c} * {{(GW-CW){1'b0}}, d};
        cross_term = $signed(p - q);
    endfunction

    function automatic logic signed [VW-1:0] det(input logic signed [DFW-1:0] a,
                                                  input logic signed [DFW-1:0] b,
                                                  input logic signed [DFW-1:0] c,
                                                  input logic signed [DFW-1:0] d);
        logic signed [VW-1:0] ea;
        logic signed [VW-1:0] eb;
        logic signed [VW-1:0] ec;
        logic signed [VW-1:0] ed;
        ea = {{(VW-DFW){a[DFW-1]}}, a};
        eb = {{(VW-DFW){b[DFW-1]}}, b};
        ec = {{(VW-DFW){c[DFW-1]}}, c};
        ed = {{(VW-DFW){d[DFW-1]}}, d};
        det = ea * eb - ec * ed;
    endfunction

    function automatic logic signed [HW-1:0] scale(input logic signed [GW-1:0] g,
                                                    input logic [CW-1:0] s);
        logic signed [HW-1:0] eg;
        logic signed [HW-1:0] es;
        eg = {{(HW-GW){g[GW-1]}}, g};
        es = $signed({{(HW-CW){1'b0}}, s});
        scale = eg * es;
    endfunction

    logic signed [DFW-1:0] r_c1_sxa, r_c1_sxb, r_c1_sya, r_c1_syb;
    logic signed [DFW-1:0] r_c1_dxa, r_c1_dxb, r_c1_dya, r_c1_dyb;
    logic signed [GW-1:0]  r_c1_gx [3];
    logic signed [GW-1:0]  r_c1_gy [3];
    logic [CW-1:0]         r_c1_sy [3];

    logic signed [VW-1:0]  r_c2_div, r_c2_a, r_c2_b, r_c2_d, r_c2_e;
    logic signed [HW-1:0]  r_c2_hx [3];
    logic signed [HW-1:0]  r_c2_hy [3];

    logic signed [VW-1:0]  r_div;
    logic signed [KW-1:0]  r_coef_a, r_coef_b, r_coef_c, r_coef_d, r_coef_e, r_coef_f;

    always_ff @(posedge i_clk) begin
        r_c1_sxa <= diff(sx[0], sx[2]);
        r_c1_sxb <= diff(sx[1], sx[2]);
        r_c1_sya <= diff(sy[0], sy[2]);
        r_c1_syb <= diff(sy[1], sy[2]);
        r_c1_dxa <= diff(dx[0], dx[2]);
        r_c1_dxb <= diff(dx[1], dx[2]);
        r_c1_dya <= diff(dy[0], dy[2]);
        r_c1_dyb <= diff(dy[1], dy[2]);
        r_c1_gx[0] <= cross_term(sx[2], dx[1], sx[1], dx[2]);
        r_c1_gx[1] <= cross_term(sx[0], dx[2], sx[2], dx[0]);
        r_c1_gx[2] <= cross_term(sx[1], dx[0], sx[0], dx[1]);
        r_c1_gy[0] <= cross_term(sx[2], dy[1], sx[1], dy[2]);
        r_c1_gy[1] <= cross_term(sx[0], dy[2], sx[2], dy[0]);
        r_c1_gy[2] <= cross_term(sx[1], dy[0], sx[0], dy[1]);
        r_c1_sy[0] <= sy[0];
        r_c1_sy[1] <= sy[1];
        r_c1_sy[2] <= sy[2];

        r_c2_div <= det(r_c1_sxa, r_c1_syb, r_c1_sxb, r_c1_sya);
        r_c2_a   <= det(r_c1_dxa, r_c1_syb, r_c1_dxb, r_c1_sya);
        r_c2_b   <= det(r_c1_sxa, r_c1_dxb, r_c1_dxa, r_c1_sxb);
        r_c2_d   <= det(r_c1_dya, r_c1_syb, r_c1_dyb, r_c1_sya);
        r_c2_e   <= det(r_c1_sxa, r_c1_dyb, r_c1_dya, r_c1_sxb);
        for (int i = 0; i < 3; i++) begin
            r_c2_hx[i] <= scale(r_c1_gx[i], r_c1_sy[i]);
            r_c2_hy[i] <= scale(r_c1_gy[i], r_c1_sy[i]);
        end

        r_div    <= r_c2_div;
        r_coef_a <= {{(KW-VW){r_c2_a[VW-1]}}, r_c2_a};
        r_coef_b <= {{(KW-VW){r_c2_b[VW-1]}}, r_c2_b};
        r_coef_d <= {{(KW-VW){r_c2_d[VW-1]}}, r_c2_d};
        r_coef_e <= {{(KW-VW){r_c2_e[VW-1]}}, r_c2_e};
        r_coef_c <= {{(KW-HW){r_c2_hx[0][HW-1]}}, r_c2_hx[0]}
                  + {{(KW-HW){r_c2_hx[1][HW-1]}}, r_c2_hx[1]}
                  + {{(KW-HW){r_c2_hx[2][HW-1]}}, r_c2_hx[2]};
        r_coef_f <= {{(KW-HW){r_c2_hy[0][HW-1]}}, r_c2_hy[0]}
                  + {{(KW-HW){r_c2_hy[1][HW-1]}}, r_c2_hy[1]}
                  + {{(KW-HW){r_c2_hy[2][HW-1]}}, r_c2_hy[2]};
    end

    // Point datapath.
    logic en;
    logic in_acc;
    logic r_s1_vld, r_s2_vld, r_s3_vld, r_out_vld;

    assign en         = !r_out_vld || i_out_ready;
    assign o_in_ready = en && (r_busy == 2'd0);
    assign in_acc     = i_in_valid && o_in_ready;

    logic signed [NW-1:0] cc_ext, cf_ext;
    logic signed [CW:0]   tx_ext, ty_ext;

    assign cc_ext = {{(NW-KW){r_coef_c[KW-1]}}, r_coef_c};
    assign cf_ext = {{(NW-KW){r_coef_f[KW-1]}}, r_coef_f};
    assign tx_ext = $signed({1'b0, i_touch_x});
    assign ty_ext = $signed({1'b0, i_touch_y});

    function automatic logic signed [NW-1:0] mul_tap(input logic signed [VW-1:0] k,
                                                      input logic signed [CW:0] t);
        logic signed [VW+CW:0] p;
        p = k * t;
        mul_tap = {{(NW-VW-CW-1){p[VW+CW]}}, p};
    endfunction

    logic signed [NW-1:0] r_s1_ax, r_s1_by, r_s1_dx, r_s1_ey;
    logic signed [NW-1:0] r_s2_nx, r_s2_ny;
    logic [MW-1:0]        r_s3_mx, r_s3_my;
    logic                 r_s3_negx, r_s3_negy;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_ax <= mul_tap(r_coef_a[VW-1:0], tx_ext);
            r_s1_by <= mul_tap(r_coef_b[VW-1:0], ty_ext);
            r_s1_dx <= mul_tap(r_coef_d[VW-1:0], tx_ext);
            r_s1_ey <= mul_tap(r_coef_e[VW-1:0], ty_ext);
            r_s2_nx <= r_s1_ax + r_s1_by + cc_ext;
            r_s2_ny <= r_s1_dx + r_s1_ey + cf_ext;
            r_s3_mx <= r_s2_nx[NW-1] ? $unsigned(-r_s2_nx) : $unsigned(r_s2_nx);
            r_s3_my <= r_s2_ny[NW-1] ? $unsigned(-r_s2_ny) : $unsigned(r_s2_ny);
            r_s3_negx <= r_s2_nx[NW-1] ^ r_div[VW-1];
            r_s3_negy <= r_s2_ny[NW-1] ^ r_div[VW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else if (en) begin
            r_s1_vld <= in_acc;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
        end
    end

    logic [VW-1:0]     den_mag;
    tpc_pkg::t_div_tag div_tag_in;
    tpc_pkg::t_div_tag div_tag_out;
    logic [MW-1:0]     quo_x, quo_y;

    assign den_mag = r_div[VW-1] ? $unsigned(-r_div) : $unsigned(r_div);
    assign div_tag_in.vld   = r_s3_vld;
    assign div_tag_in.neg_x = r_s3_negx;
    assign div_tag_in.neg_y = r_s3_negy;

    tpc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_num_x (r_s3_mx),
        .i_num_y (r_s3_my),
        .i_den   (den_mag),
        .i_tag   (div_tag_in),
        .o_quo_x (quo_x),
        .o_quo_y (quo_y),
        .o_tag   (div_tag_out)
    );

    function automatic logic [OW-1:0] sat(input logic [MW-1:0] q, input logic neg);
        logic [MW-1:0] nq;
        nq = ~q + 1'b1;
        if (neg) begin
            sat = (q > tpc_pkg::OUT_NEG_LIM) ? {1'b1, {(OW-1){1'b0}}} : nq[OW-1:0];
        end else begin
            sat = (q > tpc_pkg::OUT_POS_LIM) ? {1'b0, {(OW-1){1'b1}}} : q[OW-1:0];
        end
    endfunction

    logic zero_div;
    logic [OW-1:0] r_out_x, r_out_y;
    logic          r_out_status;

    assign zero_div = (r_div == '0);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_x      <= zero_div ? '0 : sat(quo_x, div_tag_out.neg_x);
            r_out_y      <= zero_div ? '0 : sat(quo_y, div_tag_out.neg_y);
            r_out_status <= zero_div;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= div_tag_out.vld;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_mapped_x  = $signed(r_out_x);
    assign o_mapped_y  = $signed(r_out_y);
    assign o_status    = r_out_status;

`ifndef SYNTHESIS
    a_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy != 2'd0) |-> !o_in_ready)
        else $error("input accepted while coefficients settle");

    a_cfg_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr |=> !o_in_ready)
        else $error("input ready right after a pair write");

    a_degenerate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status) |-> (o_mapped_x == '0 && o_mapped_y == '0))
        else $error("degenerate result with nonzero coordinates");
`endif

endmodule
`default_nettype wire

// ----- bench/touch_three_point_calibration_tb.sv -----
// ----------------------------------------------------------------------------
// Three-point touch calibration testbench
// Drives raw touch points with random gaps against random output stalls and
// writes calibration pairs after the points drain, predicts each mapped point
// from the affine coefficients derived from the pairs, and checks every result
// beat against the oldest prediction.
// ----------------------------------------------------------------------------
module touch_three_point_calibration_tb;

    typedef struct packed {
        logic signed [tpc_pkg::OUT_BITS-1:0] mx;
        logic signed [tpc_pkg::OUT_BITS-1:0] my;
        logic                                st;
    } t_point;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    logic [tpc_pkg::COORD_BITS-1:0] touch_x = '0;
    logic [tpc_pkg::COORD_BITS-1:0] touch_y = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic signed [tpc_pkg::OUT_BITS-1:0] mapped_x;
    logic signed [tpc_pkg::OUT_BITS-1:0] mapped_y;
    logic                           status;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [tpc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [tpc_pkg::PAIR_W-1:0]     cfg_data = '0;

    logic [tpc_pkg::PAIR_W-1:0] pair_reg [3];
    longint            coef [6];
    longint            divisor;
    t_point            pending_points [$];
    int                mismatch_count = 0;
    int                hold_cycles = 0;
    int                hold_requests = 0;
    int                hold_served = 0;

    always #6 clk = ~clk;

    touch_three_point_calibration DUT (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_touch_x(touch_x), .i_touch_y(touch_y),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_mapped_x(mapped_x), .o_mapped_y(mapped_y), .o_status(status),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    function automatic longint pair_field(logic [tpc_pkg::PAIR_W-1:0] p, int slot);
        return longint'(p[slot*tpc_pkg::COORD_BITS +: tpc_pkg::COORD_BITS]);
    endfunction

    function automatic void derive_affine();
        longint dx [3], dy [3], sx [3], sy [3];
        for (int i = 0; i < 3; i++) begin
            dx[i] = pair_field(pair_reg[i], 3);
            dy[i] = pair_field(pair_reg[i], 2);
            sx[i] = pair_field(pair_reg[i], 1);
            sy[i] = pair_field(pair_reg[i], 0);
        end
        divisor = (sx[0]-sx[2])*(sy[1]-sy[2]) - (sx[1]-sx[2])*(sy[0]-sy[2]);
        coef[0] = (dx[0]-dx[2])*(sy[1]-sy[2]) - (dx[1]-dx[2])*(sy[0]-sy[2]);
        coef[1] = (sx[0]-sx[2])*(dx[1]-dx[2]) - (dx[0]-dx[2])*(sx[1]-sx[2]);
        coef[2] = (sx[2]*dx[1]-sx[1]*dx[2])*sy[0] + (sx[0]*dx[2]-sx[2]*dx[0])*sy[1]
                + (sx[1]*dx[0]-sx[0]*dx[1])*sy[2];
        coef[3] = (dy[0]-dy[2])*(sy[1]-sy[2]) - (dy[1]-dy[2])*(sy[0]-sy[2]);
        coef[4] = (sx[0]-sx[2])*(dy[1]-dy[2]) - (dy[0]-dy[2])*(sx[1]-sx[2]);
        coef[5] = (sx[2]*dy[1]-sx[1]*dy[2])*sy[0] + (sx[0]*dy[2]-sx[2]*dy[0])*sy[1]
                + (sx[1]*dy[0]-sx[0]*dy[1])*sy[2];
    endfunction

    function automatic logic signed [tpc_pkg::OUT_BITS-1:0] clamp_coord(longint v);
        longint hi;
        hi = (64'sd1 <<< (tpc_pkg::OUT_BITS-1)) - 1;
        if (v > hi) v = hi;
        if (v < -hi-1) v = -hi-1;
        return v[tpc_pkg::OUT_BITS-1:0];
    endfunction

    function automatic t_point map_point(longint tx, longint ty);
        t_point p;
        if (divisor == 0) begin
            p = '{mx: '0, my: '0, st: 1'b1};
        end else begin
            p.mx = clamp_coord((coef[0]*tx + coef[1]*ty + coef[2]) / divisor);
            p.my = clamp_coord((coef[3]*tx + coef[4]*ty + coef[5]) / divisor);
            p.st = 1'b0;
        end
        return p;
    endfunction

    function automatic int random_gap();
        if ($urandom_range(9) < 6) return 0;
        if ($urandom_range(9) < 8) return $urandom_range(3, 1);
        return $urandom_range(40, 4);
    endfunction

    // The valid line stays high after a beat when the next one follows at
    // once; it drops during a gap and before the points drain.
    task automatic send_touch(logic [tpc_pkg::COORD_BITS-1:0] tx,
                              logic [tpc_pkg::COORD_BITS-1:0] ty,
                              bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : random_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        touch_x  <= tx;
        touch_y  <= ty;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pending_points.push_back(map_point(longint'(tx), longint'(ty)));
    endtask

    task automatic drain_points();
        in_valid <= 1'b0;
        while (pending_points.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic write_pair(logic [tpc_pkg::CFG_IDX_W-1:0] idx,
                              logic [tpc_pkg::PAIR_W-1:0] value);
        drain_points();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx <= tpc_pkg::CFG_PAIR_2) begin
            pair_reg[idx] = value;
            derive_affine();
        end
    endtask

    function automatic logic [tpc_pkg::PAIR_W-1:0] pack_pair(int dxv, int dyv,
                                                             int sxv, int syv);
        return {10'(dxv), 10'(dyv), 10'(sxv), 10'(syv)};
    endfunction

    task automatic test_identity_extremes();
        send_touch('0, '0);
        send_touch('1, '1);
        send_touch('1, '0);
        send_touch('0, '1);
        send_touch(10'h2AA, 10'h155);
        send_touch(10'h155, 10'h2AA);
    endtask

    task automatic test_degenerate();
        write_pair(tpc_pkg::CFG_PAIR_2, pack_pair(0, 1023, 1023, 0));
        write_pair(tpc_pkg::CFG_PAIR_1, pack_pair(1023, 0, 1023, 0));
        send_touch(10'd5, 10'd700);
        send_touch('1, '1);
    endtask

    task automatic test_saturation();
        write_pair(tpc_pkg::CFG_PAIR_0, pack_pair(1023, 1023, 0, 0));
        write_pair(tpc_pkg::CFG_PAIR_1, pack_pair(0, 1023, 1, 0));
        write_pair(tpc_pkg::CFG_PAIR_2, pack_pair(1023, 0, 0, 1));
        send_touch('1, '1);
        send_touch('1, '0);
        send_touch('0, '1);
        send_touch('0, '0);
        write_pair(tpc_pkg::CFG_PAIR_0, '1);
        write_pair(tpc_pkg::CFG_PAIR_1, pack_pair(0, 0, 1023, 1022));
        write_pair(tpc_pkg::CFG_PAIR_2, pack_pair(1023, 0, 1022, 1023));
        send_touch('0, '0);
        send_touch('1, '1);
        send_touch(10'd1, 10'd1000);
    endtask

    task automatic test_ignored_index();
        write_pair(2'd3, '1);
        send_touch(10'd300, 10'd600);
    endtask

    task automatic test_backpressure();
        hold_requests = hold_requests + 1;
        for (int n = 0; n < 80; n++) send_touch(10'($urandom), 10'($urandom), 1);
    endtask

    task automatic test_random_calibrations();
        for (int phase = 0; phase < 20; phase++) begin
            for (int k = 0; k < 3; k++) begin
                logic [tpc_pkg::PAIR_W-1:0] v;
                int base_x, base_y;
                base_x = $urandom_range(900, 100);
                base_y = $urandom_range(900, 100);
                if (phase % 5 == 0) v = tpc_pkg::PAIR_W'({$urandom, $urandom});
                else v = pack_pair($urandom_range(1023), $urandom_range(1023),
                                   base_x + $urandom_range(60) - 30,
                                   base_y + $urandom_range(60) - 30);
                write_pair(tpc_pkg::CFG_IDX_W'(k), v);
            end
            for (int n = 0; n < 50; n++) send_touch(10'($urandom), 10'($urandom));
        end
    endtask

    initial begin
        pair_reg[0] = tpc_pkg::PAIR_0_RST;
        pair_reg[1] = tpc_pkg::PAIR_1_RST;
        pair_reg[2] = tpc_pkg::PAIR_2_RST;
        derive_affine();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        test_identity_extremes();
        test_degenerate();
        test_saturation();
        test_ignored_index();
        test_backpressure();
        test_random_calibrations();
        drain_points();
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    always @(posedge clk) begin
        if (hold_requests != hold_served) begin
            hold_served <= hold_requests;
            hold_cycles <= 300;
            out_ready   <= 1'b0;
        end else if (hold_cycles > 0) begin
            out_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            out_ready <= ($urandom_range(9) < 7) || ($urandom_range(99) < 2 ? 1'b0 : 1'b1);
        end
    end

    always @(posedge clk) begin
        t_point want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_points.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected result beat x=%0d y=%0d status=%0d",
                             mapped_x, mapped_y, status);
            end else begin
                want = pending_points.pop_front();
                if (want.mx !== mapped_x || want.my !== mapped_y || want.st !== status) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Result beat: expected x=%0d y=%0d status=%0d, got %0d %0d %0d",
                                 want.mx, want.my, want.st, mapped_x, mapped_y, status);
                end
            end
        end
    end

    initial begin
        #3000000;
        $display("Mismatches found");
        $finish;
    end
endmodule
